### rtl/running_median_tracker_top_macros.svh
// assertion macros for the running median tracker
// used by running_median_tracker_top, no other dependencies
`ifndef RUNNING_MEDIAN_TRACKER_TOP_MACROS_SVH
`define RUNNING_MEDIAN_TRACKER_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RMT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rmt assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define RMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rmt assertion failed");

`endif

### rtl/rmt_pkg.sv
// shared types and constants for the running median tracker
// no dependencies
package rmt_pkg;

    localparam int CAPACITY = 64;
    localparam int SAMPLE_W = 32;
    localparam int MED_W    = SAMPLE_W + 1;
    localparam int KEPT_W   = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [CNT_W-1:0]           t_count;
    typedef logic [IDX_W-1:0]           t_idx;

    // what one cell hands to the next cell up the chain
    typedef struct packed {
        t_sample value;
        logic    gt;
    } t_link;

endpackage

### rtl/rmt_if.sv
// valid/ready channel interfaces for the running median tracker
// depends on rmt_pkg
interface rmt_in_if import rmt_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rmt_out_if import rmt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [MED_W-1:0] median_doubled;
    logic [KEPT_W-1:0]       kept_count;
    logic                    rejected;

    modport source (output valid, output median_doubled, output kept_count,
                    output rejected, input ready);
    modport sink   (input valid, input median_doubled, input kept_count,
                    input rejected, output ready);
endinterface

### rtl/running_median_tracker_top.sv
// running median tracker: every sample goes into an ascending chain of cells
// and each transaction returns twice the median of all samples held so far.
// channels: i_in (sample) and o_out (median_doubled, kept_count, rejected),
// both valid/ready; a transaction happens when valid and ready are high at a
// clock edge. one sample per cycle is taken while o_out is not stalled; the
// cell row shifts larger entries up in the cycle of the transaction, and the
// median is picked from the row and summed into the output register when the
// pending result moves on, which a stalled receiver can hold back.
// reset (synchronous, i_rst_n low) empties the set and drops any pending
// result. once CAPACITY samples are held further samples are dropped and
// rejected is set, with median and count of the unchanged set.
// when the receiver stalls the output register holds its result and one more
// sample may be taken; after that i_in.ready stays low until o_out moves.
// depends on rmt_pkg, rmt_if, rmt_chain, rmt_cell and the macros header
`include "running_median_tracker_top_macros.svh"

module running_median_tracker_top import rmt_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rmt_in_if.sink        i_in,
    rmt_out_if.source     o_out
);

    t_count                  r_count;
    logic                    r_pend;
    logic                    r_pend_rej;
    logic                    r_o_valid;
    logic signed [MED_W-1:0] r_med;
    logic [KEPT_W-1:0]       r_o_cnt;
    logic                    r_o_rej;

    logic    acc_in;
    logic    ins;
    logic    move;
    t_idx    lo_idx;
    t_idx    hi_idx;
    t_sample lo_val;
    t_sample hi_val;

    assign move      = r_pend && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_pend || move;
    assign acc_in    = i_in.valid && i_in.ready;
    assign ins       = acc_in && (r_count < CAP_CNT);

    assign lo_idx = IDX_W'((r_count - CNT_W'(1)) >> 1);
    assign hi_idx = IDX_W'(r_count >> 1);

    rmt_chain u_chain (
        .i_clk    (i_clk),
        .i_ins    (ins),
        .i_sample (i_in.sample),
        .i_count  (r_count),
        .i_lo_idx (lo_idx),
        .i_hi_idx (hi_idx),
        .o_lo     (lo_val),
        .o_hi     (hi_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (ins) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (acc_in) begin
                r_pend <= 1'b1;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_pend_rej <= !ins;
        end
        if (move) begin
            r_med   <= {lo_val[SAMPLE_W-1], lo_val} + {hi_val[SAMPLE_W-1], hi_val};
            r_o_cnt <= KEPT_W'(r_count);
            r_o_rej <= r_pend_rej;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.median_doubled = r_med;
    assign o_out.kept_count     = r_o_cnt;
    assign o_out.rejected       = r_o_rej;

    `RMT_ASSERT_SAME(a_count_max, 1'b1, r_count <= CAP_CNT)
    `RMT_ASSERT_NEXT(a_full_holds, acc_in && (r_count == CAP_CNT), $stable(r_count))
    `RMT_ASSERT_NEXT(a_ins_grows, ins, r_count == $past(r_count) + CNT_W'(1))
    `RMT_ASSERT_NEXT(a_move_shows, move, r_o_valid && (r_o_rej == $past(r_pend_rej)))

endmodule

### rtl/rmt_cell.sv
// one cell of the sorted insertion chain: holds one sample
// depends on rmt_pkg
module rmt_cell import rmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_ins,
    input  t_sample i_sample,
    input  t_idx    i_idx,
    input  t_count  i_count,
    input  t_idx    i_lo_idx,
    input  t_idx    i_hi_idx,
    input  t_link   i_prev,
    output t_link   o_link,
    output t_sample o_lo,
    output t_sample o_hi
);

    t_sample r_value;
    t_sample n_value;
    logic    valid;
    logic    gt;

    assign valid = (CNT_W'(i_idx) < i_count);
    assign gt    = valid && (r_value > i_sample);

    // larger entries move up one place, the first larger or free place takes the sample
    always_comb begin
        n_value = r_value;
        if (i_ins && (gt || !valid)) begin
            n_value = i_prev.gt ? i_prev.value : i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.value = r_value;
    assign o_link.gt    = gt;
    assign o_lo         = (i_idx == i_lo_idx) ? r_value : '0;
    assign o_hi         = (i_idx == i_hi_idx) ? r_value : '0;

endmodule

### rtl/rmt_chain.sv
// row of CAPACITY cells kept in ascending order, with middle-entry pick
// depends on rmt_pkg and rmt_cell
module rmt_chain import rmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_ins,
    input  t_sample i_sample,
    input  t_count  i_count,
    input  t_idx    i_lo_idx,
    input  t_idx    i_hi_idx,
    output t_sample o_lo,
    output t_sample o_hi
);

    t_link   links [CAPACITY+1];
    t_sample lo_sel [CAPACITY];
    t_sample hi_sel [CAPACITY];

    assign links[0] = '{value: '0, gt: 1'b0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        rmt_cell u_cell (
            .i_clk    (i_clk),
            .i_ins    (i_ins),
            .i_sample (i_sample),
            .i_idx    (IDX_W'(g)),
            .i_count  (i_count),
            .i_lo_idx (i_lo_idx),
            .i_hi_idx (i_hi_idx),
            .i_prev   (links[g]),
            .o_link   (links[g+1]),
            .o_lo     (lo_sel[g]),
            .o_hi     (hi_sel[g])
        );
    end

    // one-hot pick, only the selected cell drives nonzero
    always_comb begin
        o_lo = '0;
        o_hi = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            o_lo = o_lo | lo_sel[k];
            o_hi = o_hi | hi_sel[k];
        end
    end

endmodule
